>>> rtl/nmea_coordinate_to_degrees_assert.svh
// assertion macros for the coordinate converter
// used by nmea_coordinate_to_degrees; clock and reset nets must be named clock and reset
`ifndef NMEA_COORDINATE_TO_DEGREES_ASSERT_SVH
`define NMEA_COORDINATE_TO_DEGREES_ASSERT_SVH
`ifndef SYNTHESIS
`define NC2D_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nmea_c2d check failed");
`define NC2D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("nmea_c2d check failed");
`else
`define NC2D_ASSERT_IMPLIES(label, ante, cons)
`define NC2D_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/nmea_c2d_pkg.sv
// shared types, character codes and constants of the coordinate converter
// no dependencies
`default_nettype none

package nmea_c2d_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] hemisphere;
      logic       func;
   } req_type;

   typedef struct packed {
      logic signed [34:0] degrees_e7;
      logic               empty_res;
      logic               overflow;
   } rsp_type;

   // what the parser hands over at the end of a token
   typedef struct packed {
      logic [3:0]  rem_tens;
      logic [3:0]  rem_ones;
      logic [23:0] frac_e7;
      logic        negative;
      logic        empty;
      logic        overflow;
   } conv_cmd_type;

   typedef enum logic [2:0] {
      PH_INT  = 3'b001,
      PH_FRAC = 3'b010,
      PH_STOP = 3'b100
   } phase_type;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic       FUNC_LON   = 1'b1;

   // fraction digits that can change the 1e-7 result
   localparam int unsigned FRAC_E7_DIGITS = 7;
   localparam logic [23:0] E7 = 24'd10000000;
   // ceil(2^32 / 15), exact for quotients of 28-bit values
   localparam logic [28:0] RECIP_15 = 29'd286331154;

   // weight of a fraction digit by position, in 1e-7 of a minute
   function automatic logic [23:0] frac_weight(input logic [2:0] pos);
      logic [23:0] w;
      unique case (pos)
         3'd0: w = 24'd1000000;
         3'd1: w = 24'd100000;
         3'd2: w = 24'd10000;
         3'd3: w = 24'd1000;
         3'd4: w = 24'd100;
         3'd5: w = 24'd10;
         3'd6: w = 24'd1;
         default: w = 24'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/nmea_coordinate_to_degrees.sv
// top level of the NMEA ddmm.mmmm coordinate to decimal degree converter
// depends on nmea_c2d_pkg, nmea_c2d_parse, nmea_c2d_conv and the assertion header
//
// usage
//   req channel: one token character per transfer (req_data.ch); a NUL character
//     ends the token and carries the hemisphere letter and the latitude/longitude
//     select. a NUL may follow the last digit directly
//   rsp channel: one result per token, degrees in 1e-7 units plus empty and
//     overflow flags; character transfers give no result
//   throughput: one transfer per cycle on req while req_stall is low; the end-of-token
//     conversion is a four-stage pipeline behind the digit accumulate of the parser
//   result path: the NUL transfer is captured in stage 1 and passes stages 2 and 3
//     to the result register of stage 4, which presents it on rsp
//   rsp_stall: the conversion stages fill behind a stalled result; req_stall only
//     rises once all four stages hold a token, so parsing goes on meanwhile
//   reset: synchronous; clears the parser and empties the pipeline, no result
//     is presented in the cycle after reset
//   INT_DIGITS sets the width of the degree accumulator; FRAC_DIGITS the number
//     of fraction digits kept (only the first seven affect the result)
`default_nettype none

module nmea_coordinate_to_degrees #(
   parameter int INT_DIGITS  = 5,
   parameter int FRAC_DIGITS = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire nmea_c2d_pkg::req_type req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      nmea_c2d_pkg::rsp_type rsp_data
);

`include "nmea_coordinate_to_degrees_assert.svh"

   localparam int DEG_W = $clog2(10**(INT_DIGITS-2));

   logic                       take;        // a req transfer this cycle
   logic                       end_token;   // the transfer is the closing NUL
   logic                       conv_ready;
   nmea_c2d_pkg::conv_cmd_type cmd;
   logic [DEG_W-1:0]           deg;

   // the pipeline entry gates every transfer so that the parser and the
   // conversion stay in step
   assign req_stall = !conv_ready;
   assign take      = req_valid && conv_ready;
   assign end_token = take && (req_data.ch == nmea_c2d_pkg::CHAR_NUL);

   nmea_c2d_parse #(
      .INT_DIGITS  (INT_DIGITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_parse (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .cmd   (cmd),
      .deg   (deg)
   );

   nmea_c2d_conv #(
      .DEG_W (DEG_W)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (end_token),
      .in_ready  (conv_ready),
      .cmd       (cmd),
      .deg       (deg),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   // an empty token reads as zero with no overflow
   `NC2D_ASSERT_IMPLIES(a_empty_is_zero, rsp_valid && rsp_data.empty_res, rsp_data.degrees_e7 == '0 && !rsp_data.overflow)
   // input back-pressure only arises from a held result
   `NC2D_ASSERT_IMPLIES(a_stall_from_output, req_stall, rsp_valid && rsp_stall)
   // reset empties the result register
   `NC2D_ASSERT_NEXT(a_reset_clears, reset, !rsp_valid)

endmodule

`default_nettype wire

>>> rtl/nmea_c2d_parse.sv
// character parser: accumulates degree, minute and fraction digits of one token
// depends on nmea_c2d_pkg
`default_nettype none

module nmea_c2d_parse #(
   parameter int INT_DIGITS  = 5,
   parameter int FRAC_DIGITS = 6
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   take,
   input  wire nmea_c2d_pkg::req_type                  req,
   output      nmea_c2d_pkg::conv_cmd_type             cmd,
   output      logic [$clog2(10**(INT_DIGITS-2))-1:0]  deg
);

   localparam int DEG_W = $clog2(10**(INT_DIGITS-2));
   localparam int MUL_W = DEG_W + 4;
   localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(10**(INT_DIGITS-2) - 1);
   localparam int IC_W = $clog2(INT_DIGITS + 1);
   localparam int FRAC_LIM = (FRAC_DIGITS < nmea_c2d_pkg::FRAC_E7_DIGITS) ?
                             FRAC_DIGITS : nmea_c2d_pkg::FRAC_E7_DIGITS;
   localparam int FC_W = $clog2(FRAC_LIM + 1);

   logic [DEG_W-1:0]        deg_ff, deg_in;
   logic [3:0]              tens_ff, tens_in;
   logic [3:0]              ones_ff, ones_in;
   logic [23:0]             frac_ff, frac_in;
   logic [IC_W-1:0]         icnt_ff, icnt_in;
   logic [FC_W-1:0]         fcnt_ff, fcnt_in;
   nmea_c2d_pkg::phase_type phase_ff, phase_in;
   logic                    saw_ff, saw_in;
   logic                    ovf_ff, ovf_in;

   logic       is_digit;
   logic [3:0] digit;
   logic       positive;

   assign is_digit = (req.ch >= nmea_c2d_pkg::CHAR_ZERO) && (req.ch <= nmea_c2d_pkg::CHAR_NINE);
   assign digit    = req.ch[3:0];

   always_comb begin
      deg_in   = deg_ff;
      tens_in  = tens_ff;
      ones_in  = ones_ff;
      frac_in  = frac_ff;
      icnt_in  = icnt_ff;
      fcnt_in  = fcnt_ff;
      phase_in = phase_ff;
      saw_in   = saw_ff;
      ovf_in   = ovf_ff;
      if (take && req.ch != nmea_c2d_pkg::CHAR_NUL) begin
         saw_in = 1'b1;
         unique case (phase_ff)
            nmea_c2d_pkg::PH_INT: begin
               if (is_digit) begin
                  if (icnt_ff < IC_W'(INT_DIGITS)) begin
                     // shift the two minute digits along, the top one into degrees
                     deg_in  = DEG_W'(MUL_W'(deg_ff) * MUL_W'(10) + MUL_W'(tens_ff));
                     tens_in = ones_ff;
                     ones_in = digit;
                     icnt_in = icnt_ff + IC_W'(1);
                  end else begin
                     deg_in  = DEG_MAX;
                     tens_in = 4'd9;
                     ones_in = 4'd9;
                     ovf_in  = 1'b1;
                  end
               end else if (req.ch == nmea_c2d_pkg::CHAR_POINT) begin
                  phase_in = nmea_c2d_pkg::PH_FRAC;
               end else begin
                  phase_in = nmea_c2d_pkg::PH_STOP;
               end
            end
            nmea_c2d_pkg::PH_FRAC: begin
               if (is_digit) begin
                  if (fcnt_ff < FC_W'(FRAC_LIM)) begin
                     frac_in = frac_ff + 24'(digit) * nmea_c2d_pkg::frac_weight(3'(fcnt_ff));
                     fcnt_in = fcnt_ff + FC_W'(1);
                  end
               end else begin
                  phase_in = nmea_c2d_pkg::PH_STOP;
               end
            end
            default: begin
            end
         endcase
      end else if (take) begin
         // end of token: start afresh
         deg_in   = '0;
         tens_in  = '0;
         ones_in  = '0;
         frac_in  = '0;
         icnt_in  = '0;
         fcnt_in  = '0;
         phase_in = nmea_c2d_pkg::PH_INT;
         saw_in   = 1'b0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff   <= '0;
         tens_ff  <= '0;
         ones_ff  <= '0;
         frac_ff  <= '0;
         icnt_ff  <= '0;
         fcnt_ff  <= '0;
         phase_ff <= nmea_c2d_pkg::PH_INT;
         saw_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         deg_ff   <= deg_in;
         tens_ff  <= tens_in;
         ones_ff  <= ones_in;
         frac_ff  <= frac_in;
         icnt_ff  <= icnt_in;
         fcnt_ff  <= fcnt_in;
         phase_ff <= phase_in;
         saw_ff   <= saw_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign positive = (req.func == nmea_c2d_pkg::FUNC_LON) ?
                     (req.hemisphere == nmea_c2d_pkg::CHAR_E) :
                     (req.hemisphere == nmea_c2d_pkg::CHAR_N);

   always_comb begin
      cmd.rem_tens = tens_ff;
      cmd.rem_ones = ones_ff;
      cmd.frac_e7  = frac_ff;
      cmd.negative = !positive;
      cmd.empty    = !saw_ff || (req.hemisphere == nmea_c2d_pkg::CHAR_NUL);
      cmd.overflow = ovf_ff && saw_ff && (req.hemisphere != nmea_c2d_pkg::CHAR_NUL);
   end

   assign deg = deg_ff;

endmodule

`default_nettype wire

>>> rtl/nmea_c2d_conv.sv
// four-stage conversion of a finished token to signed 1e-7 degrees
// depends on nmea_c2d_pkg
`default_nettype none

module nmea_c2d_conv #(
   parameter int DEG_W = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire nmea_c2d_pkg::conv_cmd_type  cmd,
   input  wire logic [DEG_W-1:0]            deg,
   output      logic                        out_valid,
   input  wire logic                        out_stall,
   output      nmea_c2d_pkg::rsp_type       out_data
);

   logic rdy1, rdy2, rdy3, rdy4;

   // stage 1: captured token
   logic                       s1_valid_ff;
   nmea_c2d_pkg::conv_cmd_type s1_cmd_ff;
   logic [DEG_W-1:0]           s1_deg_ff;

   // stage 2: minutes numerator and scaled degrees
   logic        s2_valid_ff;
   logic [29:0] s2_num_ff, s2_num_in;
   logic [34:0] s2_deg_ff, s2_deg_in;
   logic        s2_neg_ff, s2_empty_ff, s2_ovf_ff;
   logic [6:0]  rem;

   // stage 3: minutes over sixty, signed degree part
   logic        s3_valid_ff;
   logic [23:0] s3_q_ff, s3_q_in;
   logic [34:0] s3_dsig_ff, s3_dsig_in;
   logic        s3_neg_ff, s3_empty_ff, s3_ovf_ff;
   logic [56:0] prod;

   // stage 4: result register
   logic                  s4_valid_ff;
   nmea_c2d_pkg::rsp_type s4_data_ff, s4_data_in;
   logic [34:0]           total;

   assign rdy4     = !s4_valid_ff || !out_stall;
   assign rdy3     = !s3_valid_ff || rdy4;
   assign rdy2     = !s2_valid_ff || rdy3;
   assign rdy1     = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   assign rem       = 7'(s1_cmd_ff.rem_tens) * 7'd10 + 7'(s1_cmd_ff.rem_ones);
   assign s2_num_in = 30'(rem) * 30'(nmea_c2d_pkg::E7) + 30'(s1_cmd_ff.frac_e7);
   assign s2_deg_in = 35'(s1_deg_ff) * 35'(nmea_c2d_pkg::E7);

   // divide by four exactly, then by fifteen through the reciprocal
   assign prod       = 57'(s2_num_ff[29:2]) * 57'(nmea_c2d_pkg::RECIP_15);
   assign s3_q_in    = prod[55:32];
   assign s3_dsig_in = s2_neg_ff ? (35'd0 - s2_deg_ff) : s2_deg_ff;

   assign total = s3_neg_ff ? (s3_dsig_ff - 35'(s3_q_ff)) : (s3_dsig_ff + 35'(s3_q_ff));

   always_comb begin
      s4_data_in.degrees_e7 = s3_empty_ff ? '0 : $signed(total);
      s4_data_in.empty_res  = s3_empty_ff;
      s4_data_in.overflow   = s3_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= in_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_cmd_ff <= cmd;
         s1_deg_ff <= deg;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_num_ff   <= s2_num_in;
         s2_deg_ff   <= s2_deg_in;
         s2_neg_ff   <= s1_cmd_ff.negative;
         s2_empty_ff <= s1_cmd_ff.empty;
         s2_ovf_ff   <= s1_cmd_ff.overflow;
      end
      if (rdy3 && s2_valid_ff) begin
         s3_q_ff     <= s3_q_in;
         s3_dsig_ff  <= s3_dsig_in;
         s3_neg_ff   <= s2_neg_ff;
         s3_empty_ff <= s2_empty_ff;
         s3_ovf_ff   <= s2_ovf_ff;
      end
      if (rdy4 && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

`default_nettype wire

>>> verif/nmea_c2d_checker.sv
// result checker for the coordinate converter: tracks every req transfer, works out
// the degree value each NUL transfer should give and compares it with the rsp transfers
// depends on nmea_c2d_pkg for the payload types and character codes
module nmea_c2d_checker #(
   parameter int INT_DIGITS  = 5,
   parameter int FRAC_DIGITS = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire nmea_c2d_pkg::req_type req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire nmea_c2d_pkg::rsp_type rsp_data,
   output int                         mismatch_count,
   output int                         pending_count,
   output int                         result_count
);

   import nmea_c2d_pkg::*;

   localparam int WHOLE_W = $clog2(10 ** INT_DIGITS);
   localparam int MINF_W  = $clog2(10 ** FRAC_DIGITS);
   localparam int WCNT_W  = $clog2(INT_DIGITS + 1);
   localparam int FCNT_W  = $clog2(FRAC_DIGITS + 1);

   // parser state of the token in flight
   logic [WHOLE_W-1:0] whole_acc;
   logic [MINF_W-1:0]  minute_frac;
   logic [WCNT_W-1:0]  whole_digits;
   logic [FCNT_W-1:0]  frac_digits;
   phase_type          scan_phase;
   logic               seen_char;
   logic               whole_saturated;

   rsp_type awaiting_rsp [$];
   int      mismatches = 0;
   int      results    = 0;
   int      waiting    = 0;

   assign mismatch_count = mismatches;
   assign pending_count  = waiting;
   assign result_count   = results;

   function automatic longint unsigned ten_to(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   function automatic void clear_token();
      whole_acc       = '0;
      minute_frac     = '0;
      whole_digits    = '0;
      frac_digits     = '0;
      scan_phase      = PH_INT;
      seen_char       = 1'b0;
      whole_saturated = 1'b0;
   endfunction

   function automatic void take_char(input logic [7:0] c);
      logic is_digit;
      is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      seen_char = 1'b1;
      case (scan_phase)
         PH_INT: begin
            if (is_digit) begin
               if (whole_digits < INT_DIGITS) begin
                  whole_acc    = WHOLE_W'(whole_acc * 10 + (c - CHAR_ZERO));
                  whole_digits = whole_digits + 1'b1;
               end else begin
                  // saturate, later integer digits are lost
                  whole_acc       = WHOLE_W'(ten_to(INT_DIGITS) - 1);
                  whole_saturated = 1'b1;
               end
            end else if (c == CHAR_POINT) begin
               scan_phase = PH_FRAC;
            end else begin
               scan_phase = PH_STOP;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               if (frac_digits < FRAC_DIGITS) begin
                  minute_frac = MINF_W'(minute_frac * 10 + (c - CHAR_ZERO));
                  frac_digits = frac_digits + 1'b1;
               end
            end else begin
               scan_phase = PH_STOP;
            end
         end
         default: ;
      endcase
   endfunction

   // degrees plus minutes / 60 in 1e-7 units, truncated, then signed
   function automatic rsp_type end_token(input logic [7:0] hem, input logic fn);
      rsp_type         r;
      longint unsigned deg;
      longint unsigned scale;
      longint unsigned mins;
      longint unsigned mag;
      longint unsigned signed_val;
      logic            positive;
      r = '0;
      if (!seen_char || hem == CHAR_NUL) begin
         r.empty_res = 1'b1;
      end else begin
         deg        = 64'(whole_acc / 100);
         scale      = ten_to(frac_digits);
         mins       = 64'(whole_acc % 100) * scale + 64'(minute_frac);
         mag        = deg * 64'd10000000 + (mins * 64'd10000000) / (64'd60 * scale);
         positive   = (fn == FUNC_LON) ? (hem == CHAR_E) : (hem == CHAR_N);
         signed_val = positive ? mag : 64'd0 - mag;
         r.degrees_e7 = signed_val[34:0];
         r.overflow   = whole_saturated;
      end
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input rsp_type want,
                                         input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t: %s: expected degrees %0d empty %0b overflow %0b, ",
                   "got degrees %0d empty %0b overflow %0b"},
                  $time, what, $signed(want.degrees_e7), want.empty_res, want.overflow,
                  $signed(got.degrees_e7), got.empty_res, got.overflow);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_token();
         awaiting_rsp.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_data.ch == CHAR_NUL) begin
               awaiting_rsp.push_back(end_token(req_data.hemisphere, req_data.func));
               clear_token();
            end else begin
               take_char(req_data.ch);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            results++;
            if (awaiting_rsp.size() == 0) begin
               note_mismatch("result with none outstanding", '0, rsp_data);
            end else begin
               want = awaiting_rsp.pop_front();
               if (rsp_data.degrees_e7 !== want.degrees_e7 ||
                   rsp_data.empty_res !== want.empty_res ||
                   rsp_data.overflow !== want.overflow)
                  note_mismatch("wrong result", want, rsp_data);
            end
         end
      end
      waiting = awaiting_rsp.size();
   end

endmodule

>>> verif/nmea_coordinate_to_degrees_tb.sv
// testbench top for the coordinate converter: drives NMEA tokens a character at a time
// with bursty req traffic and patterned rsp stalls; needs nmea_c2d_pkg, the block and
// nmea_c2d_checker, which does all prediction and comparison
module nmea_coordinate_to_degrees_tb;

   import nmea_c2d_pkg::*;

   localparam int INT_DIGITS  = 5;
   localparam int FRAC_DIGITS = 6;
   localparam int ITEM_TARGET = 750;
   // cycles with no transfer on either channel before the run is abandoned
   localparam int IDLE_LIMIT  = 2000;

   localparam logic [7:0] CHAR_S   = 8'h53;
   localparam logic [7:0] CHAR_W   = 8'h57;
   localparam logic       FUNC_LAT = ~FUNC_LON;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY} stall_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatches;
   int pending;
   int results;

   // token being assembled, sent character by character
   logic [7:0] token_text [$];
   int         chars_sent = 0;
   int         tokens_sent = 0;
   int         burst_left = 0;
   int         drains = 0;
   int         idle_cycles = 0;

   nmea_coordinate_to_degrees #(
      .INT_DIGITS (INT_DIGITS),
      .FRAC_DIGITS(FRAC_DIGITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   nmea_c2d_checker #(
      .INT_DIGITS (INT_DIGITS),
      .FRAC_DIGITS(FRAC_DIGITS)
   ) degree_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatches),
      .pending_count (pending),
      .result_count  (results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver stall pattern: stretches of no stall, coin-flip stall and heavy stall
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_span = 0;

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_span = $urandom_range(16, 96);
      end
      stall_span--;
      case (stall_mode)
         STALL_NONE:  rsp_stall = 1'b0;
         STALL_COIN:  rsp_stall = 1'($urandom_range(0, 1));
         default:     rsp_stall = ($urandom_range(0, 3) != 0);
      endcase
   end

   // watchdog: any transfer on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("no transfer for %0d cycles, giving up", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // a character transfer; hemisphere and func are ignored there, so they carry noise
   function automatic req_type char_item(input logic [7:0] c);
      req_type item;
      item.ch         = c;
      item.hemisphere = 8'($urandom_range(0, 255));
      item.func       = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         // new burst, often preceded by a short gap
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_data  = item;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_token(input logic [7:0] hem, input logic fn);
      req_type nul_item;
      foreach (token_text[i]) send_item(char_item(token_text[i]));
      nul_item.ch         = CHAR_NUL;
      nul_item.hemisphere = hem;
      nul_item.func       = fn;
      send_item(nul_item);
      token_text.delete();
      tokens_sent++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) token_text.push_back(s[i]);
   endtask

   // hold the sender off until every outstanding result has been taken
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      drains++;
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'(CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_hemisphere();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         case ($urandom_range(0, 3))
            0:       return CHAR_N;
            1:       return CHAR_E;
            2:       return CHAR_S;
            default: return CHAR_W;
         endcase
      end else if (pick < 95) begin
         return 8'($urandom_range(1, 255));
      end
      return CHAR_NUL;
   endfunction

   // mostly well-formed ddmm.mmmm tokens, some with stray characters, some pure noise
   task automatic build_random_token();
      int kind;
      int n_int;
      int n_frac;
      int spot;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         if ($urandom_range(0, 9) == 0)
            n_int = $urandom_range(INT_DIGITS + 1, INT_DIGITS + 3);
         else
            n_int = $urandom_range(1, INT_DIGITS);
         for (int i = 0; i < n_int; i++)
            token_text.push_back(($urandom_range(0, 7) == 0) ? CHAR_NINE : rand_digit());
         if ($urandom_range(0, 6) != 0) begin
            token_text.push_back(CHAR_POINT);
            n_frac = $urandom_range(0, FRAC_DIGITS + 3);
            for (int i = 0; i < n_frac; i++) token_text.push_back(rand_digit());
         end
         // broken sequences: a stray byte somewhere in the token
         if (kind >= 70) begin
            spot = $urandom_range(0, token_text.size());
            token_text.insert(spot, ($urandom_range(0, 1) != 0) ? CHAR_POINT
                                                                : 8'($urandom_range(1, 255)));
         end
      end else if (kind < 95) begin
         repeat ($urandom_range(1, 6)) token_text.push_back(8'($urandom_range(1, 255)));
      end
      // otherwise the token stays empty
   endtask

   initial begin
      logic [7:0] hem;
      logic       fn;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed: empty token
      send_token(CHAR_N, FUNC_LAT);
      // digits but no hemisphere
      add_text("5");
      send_token(CHAR_NUL, FUNC_LON);
      // only non-digits, not empty
      add_text("x");
      send_token(CHAR_E, FUNC_LON);
      // integer saturation, then a fraction digit after the point
      add_text("9999999.9");
      send_token(CHAR_W, FUNC_LON);
      // zero with a southern hemisphere
      add_text("0");
      send_token(CHAR_S, FUNC_LAT);
      // parsing stops at the second point; N on a longitude is negative
      add_text("1.2.3");
      send_token(CHAR_N, FUNC_LON);
      // top byte values
      token_text.push_back(8'hFF);
      send_token(8'hFF, FUNC_LAT);
      drain_results();

      // random tokens, with one pause for a full drain half way
      while (chars_sent < ITEM_TARGET) begin
         build_random_token();
         hem = rand_hemisphere();
         fn  = 1'($urandom_range(0, 1));
         send_token(hem, fn);
         if (drains == 1 && chars_sent >= ITEM_TARGET / 2) drain_results();
      end
      req_valid = 1'b0;

      // let the conversion pipeline empty, the watchdog bounds the wait
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("run covered %0d characters in %0d tokens, %0d results compared, %0d drains",
               chars_sent, tokens_sent, results, drains);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatching results", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
